// File: rtl/core/tti_pkg.sv
// shared types and constants for the text terminal control interpreter
package tti_pkg;

    localparam int ROWS_DEF    = 10;
    localparam int COLS_DEF    = 10;
    localparam int QUEUE_DEPTH = 2;

    // character codes
    localparam logic [7:0] CARET  = 8'h5E;
    localparam logic [7:0] BLANK  = 8'h20;
    localparam logic [7:0] DIGIT0 = 8'h30;
    localparam logic [7:0] DIGIT9 = 8'h39;

    // command letters that follow a caret
    localparam logic [7:0] KEY_COL0   = 8'h62;
    localparam logic [7:0] KEY_CLEAR  = 8'h63;
    localparam logic [7:0] KEY_DOWN   = 8'h64;
    localparam logic [7:0] KEY_ERASE  = 8'h65;
    localparam logic [7:0] KEY_HOME   = 8'h68;
    localparam logic [7:0] KEY_INSERT = 8'h69;
    localparam logic [7:0] KEY_LEFT   = 8'h6C;
    localparam logic [7:0] KEY_OVER   = 8'h6F;
    localparam logic [7:0] KEY_RIGHT  = 8'h72;
    localparam logic [7:0] KEY_UP     = 8'h75;

    // action codes of an input word
    localparam logic [1:0] ACT_BYTE = 2'd0;
    localparam logic [1:0] ACT_READ = 2'd1;
    localparam logic [1:0] ACT_NEW  = 2'd2;

    typedef enum logic [3:0] {
        OP_PUT,
        OP_COL0,
        OP_CLEAR,
        OP_DOWN,
        OP_UP,
        OP_LEFT,
        OP_RIGHT,
        OP_ERASE,
        OP_HOME,
        OP_INS,
        OP_OVR,
        OP_PLACE,
        OP_READ,
        OP_RESET
    } op_t;

    typedef struct packed {
        op_t        op;
        logic [7:0] data;
        logic [3:0] row;
        logic [3:0] col;
    } cmd_t;

    typedef enum logic {
        BK_IDLE,
        BK_EXEC
    } back_state_t;

endpackage

// File: rtl/core/text_terminal_control_interpreter.sv
// top level of the text terminal control interpreter
//
// input channel (in_valid / in_stall): one word per item; action selects a
// stream byte, a cell read, or a new screen. a word is taken at a rising edge
// with in_valid high and in_stall low. in_stall rises only when the two-entry
// command queue between the decoder and the executor is full.
// output channel (out_valid / out_stall): one word for each cell read, with the
// character and the cursor and mode as they stand after all earlier items.
// the result sits in an output register and holds while out_stall is high;
// the executor keeps draining the queue until it meets the next cell read.
// flow: the decoder takes one word per cycle while the queue is not full; the
// executor carries out cursor, mode, clear and new-screen commands as it pops
// them, while a write, erase or read goes through one row-wide screen memory
// in a further step (a write or erase reads the row, then writes it back).
// reset: cursor home, overwrite mode, no escape in progress, screen all blank.
// blanking is done by per-row valid bits, so clear and new screen need no
// sweep of the memory.
module text_terminal_control_interpreter
    import tti_pkg::*;
#(
    parameter int ROWS = ROWS_DEF,
    parameter int COLS = COLS_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [1:0] action,
    input  logic [7:0] stream_byte,
    input  logic [3:0] read_row,
    input  logic [3:0] read_col,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] cell_char,
    output logic [3:0] cursor_row_now,
    output logic [3:0] cursor_col_now,
    output logic       insert_on
);

    // decoder to queue
    logic q_push;
    cmd_t q_push_cmd;
    logic q_full;

    // queue to executor
    logic q_pop;
    logic q_valid;
    cmd_t q_head;

    // decoder: caret sequences, digit pairs, read clamping
    tti_front #(
        .ROWS (ROWS),
        .COLS (COLS)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .action      (action),
        .stream_byte (stream_byte),
        .read_row    (read_row),
        .read_col    (read_col),
        .q_full      (q_full),
        .q_push      (q_push),
        .q_cmd       (q_push_cmd)
    );

    // lets the decoder run ahead while the executor waits on a stalled result
    tti_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_cmd  (q_push_cmd),
        .full      (q_full),
        .pop       (q_pop),
        .pop_valid (q_valid),
        .pop_cmd   (q_head)
    );

    // executor: owns cursor, mode and the screen memory
    tti_back #(
        .ROWS (ROWS),
        .COLS (COLS)
    ) u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .q_valid        (q_valid),
        .q_cmd          (q_head),
        .q_pop          (q_pop),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .cell_char      (cell_char),
        .cursor_row_now (cursor_row_now),
        .cursor_col_now (cursor_col_now),
        .insert_on      (insert_on)
    );

endmodule

// File: rtl/core/tti_ram.sv
// generic single-port-write ram with registered read
module tti_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                      clk,
    input  logic                                      wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                          wr_data,
    input  logic                                      rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                          rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: rtl/core/tti_queue.sv
// short command queue between the decoder and the executor
module tti_queue
    import tti_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t push_cmd,
    output logic full,
    input  logic pop,
    output logic pop_valid,
    output cmd_t pop_cmd
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    cmd_t             entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign full      = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign pop_valid = (count_reg != '0);
    assign pop_cmd   = entry_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && pop_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

// File: rtl/core/tti_front.sv
// input decoder: escape sequence parsing and command classification
module tti_front
    import tti_pkg::*;
#(
    parameter int ROWS = ROWS_DEF,
    parameter int COLS = COLS_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [1:0] action,
    input  logic [7:0] stream_byte,
    input  logic [3:0] read_row,
    input  logic [3:0] read_col,
    input  logic       q_full,
    output logic       q_push,
    output cmd_t       q_cmd
);

    localparam logic [3:0] ROW_LAST = 4'(ROWS - 1);
    localparam logic [3:0] COL_LAST = 4'(COLS - 1);

    logic       esc_reg, esc_next;
    logic       await_reg, await_next;
    logic [3:0] pend_reg, pend_next;
    logic       accept;
    logic       is_digit;
    logic [7:0] byte_off;
    logic [3:0] digit_val;
    logic [3:0] place_row, place_col, rd_row, rd_col;

    assign in_stall  = q_full;
    assign accept    = in_valid && !q_full;
    assign is_digit  = stream_byte inside {[DIGIT0:DIGIT9]};
    assign byte_off  = stream_byte - DIGIT0;
    assign digit_val = byte_off[3:0];
    assign place_row = (pend_reg > ROW_LAST) ? ROW_LAST : pend_reg;
    assign place_col = (digit_val > COL_LAST) ? COL_LAST : digit_val;
    assign rd_row    = (read_row > ROW_LAST) ? ROW_LAST : read_row;
    assign rd_col    = (read_col > COL_LAST) ? COL_LAST : read_col;

    always_comb
    begin
        esc_next   = esc_reg;
        await_next = await_reg;
        pend_next  = pend_reg;
        q_push     = 1'b0;
        q_cmd.op   = OP_PUT;
        q_cmd.data = stream_byte;
        q_cmd.row  = '0;
        q_cmd.col  = '0;
        if (accept)
        begin
            case (action)
                ACT_BYTE:
                begin
                    if (await_reg)
                    begin
                        await_next = 1'b0;
                        pend_next  = '0;
                        if (is_digit)
                        begin
                            q_push    = 1'b1;
                            q_cmd.op  = OP_PLACE;
                            q_cmd.row = place_row;
                            q_cmd.col = place_col;
                        end
                    end
                    else if (esc_reg)
                    begin
                        esc_next = 1'b0;
                        q_push   = 1'b1;
                        case (stream_byte)
                            KEY_COL0:   q_cmd.op = OP_COL0;
                            KEY_CLEAR:  q_cmd.op = OP_CLEAR;
                            KEY_DOWN:   q_cmd.op = OP_DOWN;
                            KEY_UP:     q_cmd.op = OP_UP;
                            KEY_LEFT:   q_cmd.op = OP_LEFT;
                            KEY_RIGHT:  q_cmd.op = OP_RIGHT;
                            KEY_ERASE:  q_cmd.op = OP_ERASE;
                            KEY_HOME:   q_cmd.op = OP_HOME;
                            KEY_INSERT: q_cmd.op = OP_INS;
                            KEY_OVER:   q_cmd.op = OP_OVR;
                            CARET:      q_cmd.op = OP_PUT;
                            default:
                            begin
                                // digit starts cursor placement, anything else is dropped
                                q_push = 1'b0;
                                if (is_digit)
                                begin
                                    pend_next  = digit_val;
                                    await_next = 1'b1;
                                end
                            end
                        endcase
                    end
                    else if (stream_byte == CARET)
                    begin
                        esc_next = 1'b1;
                    end
                    else
                    begin
                        q_push = 1'b1;
                    end
                end
                ACT_READ:
                begin
                    q_push    = 1'b1;
                    q_cmd.op  = OP_READ;
                    q_cmd.row = rd_row;
                    q_cmd.col = rd_col;
                end
                ACT_NEW:
                begin
                    esc_next   = 1'b0;
                    await_next = 1'b0;
                    pend_next  = '0;
                    q_push     = 1'b1;
                    q_cmd.op   = OP_RESET;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            esc_reg   <= 1'b0;
            await_reg <= 1'b0;
            pend_reg  <= '0;
        end
        else
        begin
            esc_reg   <= esc_next;
            await_reg <= await_next;
            pend_reg  <= pend_next;
        end
    end

endmodule

// File: rtl/core/tti_back.sv
// command executor: cursor, mode, row read-modify-write of the screen, cell reads
module tti_back
    import tti_pkg::*;
#(
    parameter int ROWS = ROWS_DEF,
    parameter int COLS = COLS_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       q_valid,
    input  cmd_t       q_cmd,
    output logic       q_pop,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] cell_char,
    output logic [3:0] cursor_row_now,
    output logic [3:0] cursor_col_now,
    output logic       insert_on
);

    localparam int ROW_AW = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int COL_AW = $clog2(COLS);
    localparam int ROW_W  = COLS * 8;
    localparam logic [3:0] ROW_LAST = 4'(ROWS - 1);
    localparam logic [3:0] COL_LAST = 4'(COLS - 1);

    back_state_t       state_reg, state_next;
    cmd_t              cmd_reg, cmd_next;
    logic [ROW_AW-1:0] row_sel_reg, row_sel_next;
    logic [3:0]        cur_row_reg, cur_row_next;
    logic [3:0]        cur_col_reg, cur_col_next;
    logic              ins_reg, ins_next;
    logic [ROWS-1:0]   row_valid_reg, row_valid_next;
    logic              out_valid_reg, out_valid_next;
    logic [7:0]        cell_reg, cell_next;
    logic [3:0]        out_row_reg, out_row_next;
    logic [3:0]        out_col_reg, out_col_next;
    logic              out_ins_reg, out_ins_next;

    logic              out_free;
    logic              rd_en, wr_en;
    logic [ROW_AW-1:0] rd_addr;
    logic [ROW_W-1:0]  rd_data, old_row, new_row;
    logic [7:0]        old_cells [COLS];
    logic [7:0]        new_cells [COLS];

    tti_ram #(
        .WIDTH (ROW_W),
        .DEPTH (ROWS)
    ) u_screen (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (row_sel_reg),
        .wr_data (new_row),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign out_free = !out_valid_reg || !out_stall;

    // a row never written since the last clear reads as blanks
    assign old_row = row_valid_reg[row_sel_reg] ? rd_data : {COLS{BLANK}};

    always_comb
    begin
        for (int k = 0; k < COLS; k++)
        begin
            old_cells[k] = old_row[k*8 +: 8];
            new_cells[k] = old_row[k*8 +: 8];
        end
        if (cmd_reg.op == OP_PUT)
        begin
            for (int k = 1; k < COLS; k++)
            begin
                if (ins_reg && (4'(k) > cur_col_reg))
                begin
                    new_cells[k] = old_cells[k-1];
                end
            end
            for (int k = 0; k < COLS; k++)
            begin
                if (4'(k) == cur_col_reg)
                begin
                    new_cells[k] = cmd_reg.data;
                end
            end
        end
        else
        begin
            for (int k = 0; k < COLS; k++)
            begin
                if (4'(k) >= cur_col_reg)
                begin
                    new_cells[k] = BLANK;
                end
            end
        end
        for (int k = 0; k < COLS; k++)
        begin
            new_row[k*8 +: 8] = new_cells[k];
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            BK_IDLE:
            begin
                if (q_valid && (q_cmd.op inside {OP_PUT, OP_ERASE, OP_READ}))
                begin
                    state_next = BK_EXEC;
                end
            end
            BK_EXEC:
            begin
                if ((cmd_reg.op != OP_READ) || out_free)
                begin
                    state_next = BK_IDLE;
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    // actions
    always_comb
    begin
        cmd_next       = cmd_reg;
        row_sel_next   = row_sel_reg;
        cur_row_next   = cur_row_reg;
        cur_col_next   = cur_col_reg;
        ins_next       = ins_reg;
        row_valid_next = row_valid_reg;
        out_valid_next = out_valid_reg && out_stall;
        cell_next      = cell_reg;
        out_row_next   = out_row_reg;
        out_col_next   = out_col_reg;
        out_ins_next   = out_ins_reg;
        q_pop          = 1'b0;
        rd_en          = 1'b0;
        rd_addr        = cur_row_reg[ROW_AW-1:0];
        wr_en          = 1'b0;
        case (state_reg)
            BK_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop = 1'b1;
                    case (q_cmd.op)
                        OP_COL0:  cur_col_next = '0;
                        OP_CLEAR: row_valid_next = '0;
                        OP_DOWN:
                        begin
                            if (cur_row_reg < ROW_LAST)
                            begin
                                cur_row_next = cur_row_reg + 4'd1;
                            end
                        end
                        OP_UP:
                        begin
                            if (cur_row_reg != '0)
                            begin
                                cur_row_next = cur_row_reg - 4'd1;
                            end
                        end
                        OP_LEFT:
                        begin
                            if (cur_col_reg != '0)
                            begin
                                cur_col_next = cur_col_reg - 4'd1;
                            end
                        end
                        OP_RIGHT:
                        begin
                            if (cur_col_reg < COL_LAST)
                            begin
                                cur_col_next = cur_col_reg + 4'd1;
                            end
                        end
                        OP_HOME:
                        begin
                            cur_row_next = '0;
                            cur_col_next = '0;
                        end
                        OP_INS: ins_next = 1'b1;
                        OP_OVR: ins_next = 1'b0;
                        OP_PLACE:
                        begin
                            cur_row_next = q_cmd.row;
                            cur_col_next = q_cmd.col;
                        end
                        OP_RESET:
                        begin
                            cur_row_next   = '0;
                            cur_col_next   = '0;
                            ins_next       = 1'b0;
                            row_valid_next = '0;
                        end
                        OP_PUT, OP_ERASE:
                        begin
                            rd_en        = 1'b1;
                            rd_addr      = cur_row_reg[ROW_AW-1:0];
                            row_sel_next = cur_row_reg[ROW_AW-1:0];
                            cmd_next     = q_cmd;
                        end
                        OP_READ:
                        begin
                            rd_en        = 1'b1;
                            rd_addr      = q_cmd.row[ROW_AW-1:0];
                            row_sel_next = q_cmd.row[ROW_AW-1:0];
                            cmd_next     = q_cmd;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            BK_EXEC:
            begin
                case (cmd_reg.op)
                    OP_PUT:
                    begin
                        wr_en                       = 1'b1;
                        row_valid_next[row_sel_reg] = 1'b1;
                        if (cur_col_reg < COL_LAST)
                        begin
                            cur_col_next = cur_col_reg + 4'd1;
                        end
                    end
                    OP_ERASE:
                    begin
                        wr_en                       = 1'b1;
                        row_valid_next[row_sel_reg] = 1'b1;
                    end
                    OP_READ:
                    begin
                        if (out_free)
                        begin
                            out_valid_next = 1'b1;
                            cell_next      = old_cells[cmd_reg.col[COL_AW-1:0]];
                            out_row_next   = cur_row_reg;
                            out_col_next   = cur_col_reg;
                            out_ins_next   = ins_reg;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            cur_row_reg   <= '0;
            cur_col_reg   <= '0;
            ins_reg       <= 1'b0;
            row_valid_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cur_row_reg   <= cur_row_next;
            cur_col_reg   <= cur_col_next;
            ins_reg       <= ins_next;
            row_valid_reg <= row_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg     <= cmd_next;
        row_sel_reg <= row_sel_next;
        cell_reg    <= cell_next;
        out_row_reg <= out_row_next;
        out_col_reg <= out_col_next;
        out_ins_reg <= out_ins_next;
    end

    assign out_valid      = out_valid_reg;
    assign cell_char      = cell_reg;
    assign cursor_row_now = out_row_reg;
    assign cursor_col_now = out_col_reg;
    assign insert_on      = out_ins_reg;

    a_pop_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> (state_reg == BK_IDLE))
        else $error("queue popped while a row access is in flight");

    a_exec_row_op: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == BK_EXEC) |->
        (cmd_reg.op == OP_PUT || cmd_reg.op == OP_ERASE || cmd_reg.op == OP_READ))
        else $error("row access state holds a command without row access");

    a_read_loads_out: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == BK_EXEC && cmd_reg.op == OP_READ && out_free) |=>
        (out_valid_reg && state_reg == BK_IDLE))
        else $error("cell read did not reach the output register");

    a_cursor_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (cur_row_reg <= ROW_LAST) && (cur_col_reg <= COL_LAST))
        else $error("cursor left the screen");

    a_write_in_exec: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> (state_reg == BK_EXEC && !rd_en))
        else $error("screen write outside the row update step");

endmodule
